>>> rtl/core/cchf_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step of the command frame hunter.
// Used by the response interface, byte queue, register block, hunter and top level.
// No dependencies.
package cchf_pkg;

   // Frame layout
   localparam int FRAME_BYTES = 16;
   localparam int CRC_SPAN    = FRAME_BYTES - 4;
   localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
   localparam int SPAN_IDX_W  = $clog2(CRC_SPAN);

   // Command codes
   localparam int CODE_COUNT = 5;
   localparam int CMD_IDX_W  = 3;

   // Input queue
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_CODE_WRITE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CODE_READ    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CODE_JUMP    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CODE_SPEED   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CODE_RAW_BUS = 3'd4;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_XOR  = 32'hFFFF_FFFF;

   typedef logic [CMD_IDX_W-1:0] cmd_index_type;
   typedef logic [CODE_COUNT-1:0][31:0] code_set_type;

   // Byte offered by the queue to the hunter
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CRC,
      ST_CHECK
   } hunt_state_type;

   // Fold one byte into a reflected CRC-32 register
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/cchf_if.sv
// Valid/ready channel interfaces of the command frame hunter: byte requests in, commands out.
// Depends on cchf_pkg.
interface cchf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cchf_rsp_if;
   import cchf_pkg::*;
   logic          valid;
   logic          ready;
   cmd_index_type command_index;
   logic [31:0]   first_argument;
   logic [31:0]   second_argument;

   modport source (output valid, output command_index, output first_argument,
                   output second_argument, input ready);
   modport sink (input valid, input command_index, input first_argument,
                 input second_argument, output ready);
endinterface

>>> rtl/core/crc_checked_command_frame_hunter.sv
// CRC-checked command frame hunter.
// Request channel (req_chan): one serial byte per request, valid/ready handshake.
// Response channel (rsp_chan): command index and two argument words of a found frame.
// Register port: APB-style, pready always high; five 32-bit command code registers at
// byte addresses 0..16, written by the user only while the block is idle (unenforced).
// Requests enter a short FIFO (QUEUE_DEPTH bytes) and are shifted straight in while the
// 16-byte window is still filling. Once the window is full, each byte is shifted in,
// then the byte-wide CRC unit folds window bytes 0..11 in turn, then the CRC and the
// command codes are compared; no new byte leaves the FIFO until that check is done.
// A response is registered at the check of the byte that completes a valid frame.
// At most one response is produced per byte. A stalled response holds its register;
// the hunter keeps shifting and checking bytes and waits only when a second frame
// is found before the first response is taken. Requests back up once the FIFO fills.
// Reset (synchronous, active high) empties the FIFO and the window and clears the
// code registers to zero.
// Depends on cchf_pkg, cchf_if, cchf_byte_queue, cchf_csr and cchf_hunter.
module crc_checked_command_frame_hunter #(
   parameter int QUEUE_DEPTH = cchf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cchf_req_if.sink                        req_chan,
   cchf_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cchf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cchf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cchf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import cchf_pkg::*;

   queue_head_type head;
   logic           pop;
   code_set_type   codes;

   // Front: request byte FIFO
   cchf_byte_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   // Command code registers
   cchf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .codes   (codes)
   );

   // Back: window, CRC and response
   cchf_hunter u_hunter (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .codes    (codes),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/core/cchf_byte_queue.sv
// Front end: accepts request bytes into a short FIFO that the hunter drains.
// Depends on cchf_pkg and cchf_if.
module cchf_byte_queue #(
   parameter int DEPTH = cchf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   cchf_req_if.sink                req_chan,
   output cchf_pkg::queue_head_type head,
   input  logic                    pop
);
   import cchf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [7:0]       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             take;

   assign req_chan.ready = (count_ff != FULL_CNT);
   assign push           = req_chan.valid && req_chan.ready;
   assign take           = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the accepted request byte
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_chan.rx_byte;
      end
   end

endmodule

>>> rtl/core/cchf_csr.sv
// Register block: five command code registers behind an APB-style write/read port.
// Depends on cchf_pkg.
module cchf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cchf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cchf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cchf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output cchf_pkg::code_set_type        codes
);
   import cchf_pkg::*;

   code_set_type         codes_ff, codes_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign codes   = codes_ff;

   // Decode the write
   always_comb begin
      codes_in = codes_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CODE_WRITE:   codes_in[0] = pwdata;
            REG_CODE_READ:    codes_in[1] = pwdata;
            REG_CODE_JUMP:    codes_in[2] = pwdata;
            REG_CODE_SPEED:   codes_in[3] = pwdata;
            REG_CODE_RAW_BUS: codes_in[4] = pwdata;
            default:          codes_in = codes_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_CODE_WRITE:   prdata = codes_ff[0];
         REG_CODE_READ:    prdata = codes_ff[1];
         REG_CODE_JUMP:    prdata = codes_ff[2];
         REG_CODE_SPEED:   prdata = codes_ff[3];
         REG_CODE_RAW_BUS: prdata = codes_ff[4];
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '0;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

>>> rtl/core/cchf_hunter.sv
// Back end: shifts bytes into the 16-byte window, runs the CRC one byte a cycle,
// matches the command word and drives the registered response. Depends on cchf_pkg, cchf_if.
module cchf_hunter (
   input  logic                     clock,
   input  logic                     reset,
   input  cchf_pkg::queue_head_type head,
   output logic                     pop,
   input  cchf_pkg::code_set_type   codes,
   cchf_rsp_if.source               rsp_chan
);
   import cchf_pkg::*;

   localparam logic [FILL_W-1:0]     FULL_FILL = FILL_W'(FRAME_BYTES);
   localparam logic [FILL_W-1:0]     HUNT_FILL = FILL_W'(FRAME_BYTES - 1);
   localparam logic [SPAN_IDX_W-1:0] LAST_IDX  = SPAN_IDX_W'(CRC_SPAN - 1);

   hunt_state_type        state_ff, state_in;
   logic [7:0]            window_ff [FRAME_BYTES];
   logic                  shift_en;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SPAN_IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]           crc_ff, crc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   cmd_index_type         cmd_idx_ff;
   logic [31:0]           arg0_ff, arg1_ff;
   logic                  load_rsp;

   logic [31:0]           cmd_word, arg0_word, arg1_word, crc_word;
   logic                  code_hit;
   cmd_index_type         hit_idx;
   logic                  out_free;

   assign cmd_word  = {window_ff[3], window_ff[2], window_ff[1], window_ff[0]};
   assign arg0_word = {window_ff[7], window_ff[6], window_ff[5], window_ff[4]};
   assign arg1_word = {window_ff[11], window_ff[10], window_ff[9], window_ff[8]};
   assign crc_word  = {window_ff[15], window_ff[14], window_ff[13], window_ff[12]};

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Match the command word, lowest index wins
   always_comb begin
      code_hit = 1'b0;
      hit_idx  = '0;
      for (int i = CODE_COUNT - 1; i >= 0; i--) begin
         if (cmd_word == codes[i]) begin
            code_hit = 1'b1;
            hit_idx  = CMD_IDX_W'(i);
         end
      end
   end

   // Sequence: take byte, fold CRC over the first twelve bytes, check
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      pop      = 1'b0;
      shift_en = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               shift_en = 1'b1;
               fill_in  = fill_ff + 1'b1;
               idx_in   = '0;
               crc_in   = CRC_INIT;
               if (fill_ff == HUNT_FILL) begin
                  state_in = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            crc_in = crc32_byte(crc_ff, window_ff[idx_ff]);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (((crc_ff ^ CRC_XOR) == crc_word) && code_hit) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               fill_in  = HUNT_FILL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold CRC state and byte index
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      crc_ff <= crc_in;
   end

   // Shift the window: newest byte enters at the top, oldest drops out
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
         window_ff[FRAME_BYTES - 1] <= head.data;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         cmd_idx_ff <= hit_idx;
         arg0_ff    <= arg0_word;
         arg1_ff    <= arg1_word;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.command_index   = cmd_idx_ff;
   assign rsp_chan.first_argument  = arg0_ff;
   assign rsp_chan.second_argument = arg1_ff;

endmodule
